>>> rtl/signed_decimal_formatter_unit_assert.svh
// assertion macros used by the checker file
`ifndef SIGNED_DECIMAL_FORMATTER_UNIT_ASSERT_SVH
`define SIGNED_DECIMAL_FORMATTER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define SDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/sdf_pkg.sv
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int MAG_W      = 32;
  localparam int DIGITS     = 10;
  localparam int STEP_BITS  = 2;
  localparam int CONV_STEPS = MAG_W / STEP_BITS;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int ND_W       = $clog2(DIGITS + 1);
  localparam int DIDX_W     = $clog2(DIGITS);
  localparam int LEN_W      = 6;

  localparam logic [LEN_W-1:0] MAX_WIDTH = 6'd32;
  localparam logic [LEN_W-1:0] LEN_CAP   = 6'd63;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/sdf_cell.sv
`timescale 1ns / 1ps

// one bcd digit of the double-dabble chain, two input bits per cycle while shifting
module sdf_cell import sdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [STEP_BITS-1:0] carry_i,
  output logic [STEP_BITS-1:0] carry_o,
  output logic [3:0]           digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj1, mid, adj2;

  always_comb begin
    // add 3 to digits of 5 or more, then shift in the next bit; both steps run twice
    adj1 = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    mid  = {adj1[2:0], carry_i[1]};
    adj2 = (mid >= 4'd5) ? mid + 4'd3 : mid;
    carry_o = {adj1[3], adj2[3]};
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj2[2:0], carry_i[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

>>> rtl/signed_decimal_formatter_unit.sv
`timescale 1ns / 1ps

// channel  | signals                                       | direction
// request  | in_valid_i in_ready_o value_i min_width_i     | in
//          | pad_char_i capacity_i                         |
// result   | out_valid_o out_ready_i ch_o total_len_o      | out
//          | written_o last_o                              |
//
// a request is taken only when the block is idle, then the ten-cell bcd chain
// shifts in the magnitude two bits per cycle, a size state sizes the field,
// and results leave one per cycle while the receiver is ready.
// reset is asynchronous, active low, and clears all control state.
// a stalled result holds in the output register; the next request is taken
// while the final result of the previous one still waits.
module signed_decimal_formatter_unit import sdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  min_width_i,
  input  logic [7:0]  pad_char_i,
  input  logic [7:0]  capacity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  ch_o,
  output logic [5:0]  total_len_o,
  output logic        written_o,
  output logic        last_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;

  logic [MAG_W-1:0] mag_q, mag_d;
  logic             neg_q;
  logic [5:0]       width_q;
  logic [7:0]       pad_q;
  logic [7:0]       cap_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [ND_W-1:0]  nd_q, nd_d;
  logic             size_only_q, size_only_d;

  logic [7:0]       ch_q, ch_d;
  logic [LEN_W-1:0] tlen_q;
  logic             written_q, written_d;
  logic             last_q, last_d;

  logic             accept;
  logic             out_load;
  cell_ctrl_t       cell_ctrl;
  logic [STEP_BITS-1:0] chain [DIGITS];
  logic [3:0]       digit [DIGITS];

  logic [5:0]       width_sat;
  logic [6:0]       len_dig, len_min, len_max;
  logic [LEN_W-1:0] dstart;
  logic [LEN_W-1:0] didx_full;
  logic [DIDX_W-1:0] didx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = !out_valid_q || out_ready_i;

  assign cell_ctrl.clear = accept;
  assign cell_ctrl.shift = (state_q == ST_CONV);
  assign chain[0]        = mag_q[MAG_W-1 -: STEP_BITS];

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    if (g < DIGITS - 1) begin : g_mid
      sdf_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .carry_i (chain[g]),
        .carry_o (chain[g+1]),
        .digit_o (digit[g])
      );
    end else begin : g_top
      // the top digit never overflows for a 32-bit magnitude
      sdf_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .carry_i (chain[g]),
        .carry_o (),
        .digit_o (digit[g])
      );
    end
  end

  // digit count and field length
  always_comb begin
    nd_d = ND_W'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (digit[i] != 4'd0) begin
        nd_d = ND_W'(i + 1);
      end
    end
    width_sat = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
    len_dig   = 7'(nd_d) + {6'd0, neg_q};
    len_min   = (width_sat != 6'd0) ? ({1'b0, width_sat} + {6'd0, neg_q}) : 7'd0;
    len_max   = (len_min > len_dig) ? len_min : len_dig;
    len_d     = (len_max > {1'b0, LEN_CAP}) ? LEN_CAP : len_max[LEN_W-1:0];
    size_only_d = ({1'b0, cap_q} < ({3'd0, len_d} + 9'd1));
  end

  // character at the current position
  always_comb begin
    dstart    = len_q - LEN_W'(nd_q);
    didx_full = len_q - LEN_W'(1) - pos_q;
    didx      = didx_full[DIDX_W-1:0];
    written_d = 1'b1;
    last_d    = (pos_q + LEN_W'(1) == len_q);
    if (size_only_q) begin
      ch_d      = CH_NONE;
      written_d = 1'b0;
      last_d    = 1'b1;
    end else if (neg_q && (pos_q == '0)) begin
      ch_d = CH_MINUS;
    end else if (pos_q < dstart) begin
      ch_d = pad_q;
    end else begin
      ch_d = CH_ZERO + {4'd0, digit[didx]};
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mag_d       = mag_q;
    if (accept) begin
      mag_d = value_i[31] ? (32'd0 - value_i) : value_i;
    end else if (state_q == ST_CONV) begin
      mag_d = mag_q << STEP_BITS;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CONV;
          cnt_d   = '0;
        end
      end
      ST_CONV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_d = ST_EMIT;
        pos_d   = '0;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          pos_d       = pos_q + LEN_W'(1);
          if (last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (accept) begin
      neg_q   <= value_i[31];
      width_q <= min_width_i;
      pad_q   <= (pad_char_i == 8'd0) ? CH_SPACE : pad_char_i;
      cap_q   <= capacity_i;
    end
    if (state_q == ST_SIZE) begin
      len_q       <= len_d;
      nd_q        <= nd_d;
      size_only_q <= size_only_d;
    end
    if ((state_q == ST_EMIT) && out_load) begin
      ch_q      <= ch_d;
      tlen_q    <= len_q;
      written_q <= written_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ch_o        = ch_q;
  assign total_len_o = tlen_q;
  assign written_o   = written_q;
  assign last_o      = last_q;

endmodule

>>> rtl/sdf_checker.sv
`timescale 1ns / 1ps
`include "signed_decimal_formatter_unit_assert.svh"

module sdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] value_i,
  input logic [5:0]  min_width_i,
  input logic [7:0]  pad_char_i,
  input logic [7:0]  capacity_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  ch_o,
  input logic [5:0]  total_len_o,
  input logic        written_o,
  input logic        last_o
);

  // stalled result keeps its payload
  `SDF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(ch_o) && $stable(total_len_o) && $stable(written_o) && $stable(last_o), "stalled result changed")

  `SDF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // a size-only answer is always the single final result
  `SDF_ASSERT(a_size_only_last, out_valid_o && !written_o |-> last_o, "size-only result not last")

  `SDF_ASSERT(a_len_nonzero, out_valid_o |-> total_len_o != 6'd0, "zero length reported")

  // conversion blocks new requests right after one is taken
  `SDF_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after request")

endmodule

bind signed_decimal_formatter_unit sdf_checker u_sdf_checker (.*);

>>> bench/signed_decimal_formatter_unit_tb.sv
`timescale 1ns / 1ps

module signed_decimal_formatter_unit_tb;
  import sdf_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  min_width;
    logic [7:0]  pad;
    logic [7:0]  cap;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [5:0] total_len;
    logic       written;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i = '0;
  logic [5:0]  min_width_i = '0;
  logic [7:0]  pad_char_i = '0;
  logic [7:0]  capacity_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  ch_o;
  logic [5:0]  total_len_o;
  logic        written_o;
  logic        last_o;

  fmt_req_t   pending_reqs[$];
  text_char_t expected_text[$];
  fmt_req_t   req_now;

  int accepted_cnt = 0;
  int negative_cnt = 0;
  int size_only_cnt = 0;
  int chars_checked = 0;
  int mismatch_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  logic hold_off = 1'b0;

  signed_decimal_formatter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .min_width_i(min_width_i),
    .pad_char_i (pad_char_i),
    .capacity_i (capacity_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ch_o       (ch_o),
    .total_len_o(total_len_o),
    .written_o  (written_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // builds the expected characters of one request and queues them
  task automatic predict_text(input logic [31:0] value, input logic [5:0] min_width,
                              input logic [7:0] pad, input logic [7:0] cap);
    logic        neg;
    logic [31:0] mag;
    logic [7:0]  digs[10];
    logic [7:0]  text[$];
    logic [7:0]  fill;
    int          nd;
    int          w;
    int          len;
    neg = value[31];
    mag = neg ? (32'd0 - value) : value;
    nd = 0;
    do begin
      digs[nd] = CH_ZERO + 8'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 0 && nd < 10);
    w = (min_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(min_width);
    len = nd + int'(neg);
    if (w > 0 && w + int'(neg) > len) len = w + int'(neg);
    if (len > int'(LEN_CAP)) len = int'(LEN_CAP);
    if (int'(cap) < len + 1) begin
      expected_text.push_back({CH_NONE, 6'(len), 1'b0, 1'b1});
      size_only_cnt++;
      return;
    end
    fill = (pad == 8'h00) ? CH_SPACE : pad;
    if (neg) text.push_back(CH_MINUS);
    // padding sits between the sign and the digits
    while (text.size() < len - nd) text.push_back(fill);
    for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
    foreach (text[i]) expected_text.push_back({text[i], 6'(len), 1'b1, 1'b1 && (i == len - 1)});
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] lim;
    logic [31:0] mag;
    int          k;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      default: begin
        k = $urandom_range(1, 10);
        lim = 1;
        for (int i = 0; i < k; i++) lim = lim * 10;
        mag = (k == 10) ? $urandom() : $urandom() % lim;
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
      end
    endcase
  endfunction

  function automatic fmt_req_t rand_req();
    fmt_req_t r;
    int       pick;
    r.value = rand_value();
    pick = $urandom_range(0, 19);
    if (pick < 10) r.min_width = 6'd0;
    else if (pick < 16) r.min_width = 6'($urandom_range(1, 12));
    else if (pick < 19) r.min_width = 6'($urandom_range(13, 32));
    else r.min_width = 6'($urandom_range(33, 63));
    r.pad = $urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom_range(1, 255));
    pick = $urandom_range(0, 9);
    if (pick < 6) r.cap = 8'($urandom_range(40, 255));
    else if (pick < 9) r.cap = 8'($urandom_range(0, 40));
    else r.cap = 8'hFF;
    return r;
  endfunction

  // sender: bursts of requests with random gaps in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_text(value_i, min_width_i, pad_char_i, capacity_i);
        accepted_cnt++;
        if (value_i[31]) negative_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_now = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          value_i <= req_now.value;
          min_width_i <= req_now.min_width;
          pad_char_i <= req_now.pad;
          capacity_i <= req_now.cap;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each character and stalls in phases of varying density
  always @(posedge clk_i) begin
    text_char_t want;
    text_char_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {ch_o, total_len_o, written_o, last_o};
        if (expected_text.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result ch=%02h total_len=%0d written=%0b last=%0b",
                     $realtime, ch_o, total_len_o, written_o, last_o);
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: exp/act ch=%02h/%02h len=%0d/%0d wr=%0b/%0b last=%0b/%0b",
                       $realtime, want.ch, got.ch, want.total_len, got.total_len,
                       want.written, got.written, want.last, got.last);
          end
        end
      end
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_left--;
      end
      out_ready_i <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one long receiver stall so the block backs up and stops taking requests
  initial begin
    while (accepted_cnt < 40) @(posedge clk_i);
    hold_off <= 1'b1;
    for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d characters still expected", expected_text.size());
    $display("FAIL signed_decimal_formatter_unit");
    $finish;
  end

  initial begin
    // zero, one digit, sizes at and around the capacity limit
    pending_reqs.push_back('{32'd0, 6'd0, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'd0, 6'd0, 8'h00, 8'h00});
    pending_reqs.push_back('{32'd0, 6'd0, 8'h00, 8'h01});
    pending_reqs.push_back('{32'd0, 6'd0, 8'h00, 8'h02});
    pending_reqs.push_back('{32'd1, 6'd5, 8'h2A, 8'hFF});
    pending_reqs.push_back('{32'hFFFF_FFFF, 6'd0, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'hFFFF_FFFF, 6'd4, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'hFFFF_FFFF, 6'd4, 8'h30, 8'hFF});
    pending_reqs.push_back('{32'h7FFF_FFFF, 6'd0, 8'h00, 8'd11});
    pending_reqs.push_back('{32'h7FFF_FFFF, 6'd0, 8'h00, 8'd10});
    // most negative value, with and without the widest field
    pending_reqs.push_back('{32'h8000_0000, 6'd0, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'h8000_0000, 6'd32, 8'hFF, 8'hFF});
    pending_reqs.push_back('{32'h8000_0000, 6'd32, 8'h00, 8'd33});
    pending_reqs.push_back('{32'h8000_0000, 6'd32, 8'h00, 8'd34});
    // widths beyond the maximum saturate, then mixed widths, pads and capacities
    pending_reqs.push_back('{32'd12345, 6'd63, 8'h55, 8'hFF});
    pending_reqs.push_back('{32'hFFFF_CFC7, 6'd33, 8'hAA, 8'hFF});
    pending_reqs.push_back('{32'd987654321, 6'd42, 8'h01, 8'hFF});
    pending_reqs.push_back('{32'h5555_5555, 6'h15, 8'h80, 8'hAA});
    pending_reqs.push_back('{32'hAAAA_AAAA, 6'h2A, 8'h7F, 8'h55});
    pending_reqs.push_back('{32'd10, 6'd1, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'hFFFF_FFF6, 6'd2, 8'h00, 8'hFF});
    pending_reqs.push_back('{32'd1000000000, 6'd10, 8'h00, 8'd11});
    pending_reqs.push_back('{32'hFFFF_FFFB, 6'd0, 8'h00, 8'd3});
    for (int i = 0; i < 137; i++) pending_reqs.push_back(rand_req());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_text.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d requests (%0d negative, %0d size-only answers), %0d characters",
             accepted_cnt, negative_cnt, size_only_cnt, chars_checked);
    $display("widths 0..63, pads 0..255, capacities 0..255, one %0d-cycle receiver hold-off",
             hold_cycles);
    if (mismatch_cnt == 0) begin
      $display("PASS signed_decimal_formatter_unit");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAIL signed_decimal_formatter_unit");
    end
    $finish;
  end

endmodule
